### rtl/hmt_pkg.sv
// shared types and constants of the homogeneous matrix transform
package hmt_pkg;

   localparam int DIM    = 4;
   localparam int DATA_W = 32;
   localparam int PROD_W = 2 * DATA_W;
   localparam int PAIR_W = PROD_W + 1;
   localparam int SUM_W  = PROD_W + 2;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_POINT  = 2'd1,
      ACT_ROWMUL = 2'd2
   } action_type;

   typedef logic signed [DATA_W-1:0] fix_type;
   typedef fix_type [DIM-1:0] fixvec_type;

   typedef struct packed {
      logic [1:0]               action;
      logic [1:0]               row_index;
      logic signed [DATA_W-1:0] in_a;
      logic signed [DATA_W-1:0] in_b;
      logic signed [DATA_W-1:0] in_c;
      logic signed [DATA_W-1:0] in_d;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] out_a;
      logic signed [DATA_W-1:0] out_b;
      logic signed [DATA_W-1:0] out_c;
      logic signed [DATA_W-1:0] out_d;
      logic                     saturated;
   } rsp_type;

   // per-stage load enables handed to each lane
   typedef struct packed {
      logic en_mul;
      logic en_pair;
      logic en_sum;
      logic en_out;
   } lane_ctl_type;

endpackage

### rtl/homogeneous_matrix_transform.sv
// top level of the 4x4 homogeneous matrix transform pipeline
//
// usage
//   req channel: one word per item; action load writes one matrix row and
//   gives no response, action point returns M * (x,y,z,1), action rowmul
//   returns the row (a,b,c,d) * M; the unused action code is taken and dropped
//   rsp channel: one word per point or rowmul item, in order, each component
//   floor-shifted back to the fixed-point format and clipped to 32 bits,
//   saturated set if any component clipped
//   pipeline: each word passes the operand, product, pair-sum, sum and
//   output registers before rsp_valid rises; one word per cycle while
//   rsp_ready stays high; sixteen 32x32 multipliers (four lanes of four)
//   loads update the matrix at acceptance, so later items see the new row
//   at once and earlier items keep the operands they captured
//   reset: matrix returns to identity and the pipeline empties
//   stall: each stage takes a new word when it is empty or its successor
//   moves, so bubbles collapse and req_ready drops only when every stage
//   holds a word and rsp_ready is low
module homogeneous_matrix_transform #(
   parameter int FRAC_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  hmt_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output hmt_pkg::rsp_type rsp_data
);
   import hmt_pkg::*;

   localparam logic [DATA_W-1:0] ONE_FIX = DATA_W'(1) << FRAC_BITS;

   // matrix storage, row major
   fixvec_type matrix_ff [DIM];

   // operand stage
   fixvec_type vec_in;
   fixvec_type vec_ff;
   fixvec_type coef_in [DIM];
   fixvec_type coef_ff [DIM];

   // valid bits that travel with each stage
   logic op_vld_ff,  op_vld_in;
   logic mul_vld_ff;
   logic pair_vld_ff;
   logic sum_vld_ff;
   logic rsp_vld_ff;

   logic rdy_out, rdy_sum, rdy_pair, rdy_mul;
   logic req_fire, is_point, is_calc, is_load;

   lane_ctl_type lane_ctl;
   fix_type      lane_res [DIM];
   logic [DIM-1:0] lane_sat;

   // ready chain, from the output back to the input
   assign rdy_out   = !rsp_vld_ff  || rsp_ready;
   assign rdy_sum   = !sum_vld_ff  || rdy_out;
   assign rdy_pair  = !pair_vld_ff || rdy_sum;
   assign rdy_mul   = !mul_vld_ff  || rdy_pair;
   assign req_ready = !op_vld_ff   || rdy_mul;

   assign req_fire = req_valid && req_ready;
   assign is_point = (req_data.action == ACT_POINT);
   assign is_load  = (req_data.action == ACT_LOAD);
   assign is_calc  = is_point || (req_data.action == ACT_ROWMUL);
   assign op_vld_in = req_fire ? is_calc : (op_vld_ff && !rdy_mul);

   // point uses matrix rows, rowmul uses matrix columns
   always_comb begin
      vec_in[0] = req_data.in_a;
      vec_in[1] = req_data.in_b;
      vec_in[2] = req_data.in_c;
      vec_in[3] = is_point ? fix_type'(ONE_FIX) : req_data.in_d;
      for (int i = 0; i < DIM; i++) begin
         for (int k = 0; k < DIM; k++) begin
            coef_in[i][k] = is_point ? matrix_ff[i][k] : matrix_ff[k][i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DIM; i++) begin
            for (int k = 0; k < DIM; k++) begin
               matrix_ff[i][k] <= (i == k) ? fix_type'(ONE_FIX) : '0;
            end
         end
         op_vld_ff   <= 1'b0;
         mul_vld_ff  <= 1'b0;
         pair_vld_ff <= 1'b0;
         sum_vld_ff  <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (req_fire && is_load) begin
            matrix_ff[req_data.row_index][0] <= req_data.in_a;
            matrix_ff[req_data.row_index][1] <= req_data.in_b;
            matrix_ff[req_data.row_index][2] <= req_data.in_c;
            matrix_ff[req_data.row_index][3] <= req_data.in_d;
         end
         op_vld_ff <= op_vld_in;
         if (rdy_mul)  mul_vld_ff  <= op_vld_ff;
         if (rdy_pair) pair_vld_ff <= mul_vld_ff;
         if (rdy_sum)  sum_vld_ff  <= pair_vld_ff;
         if (rdy_out)  rsp_vld_ff  <= sum_vld_ff;
      end
   end

   // operand capture, taken with the word so later loads cannot disturb it
   always_ff @(posedge clock) begin
      if (req_fire) begin
         vec_ff <= vec_in;
         for (int i = 0; i < DIM; i++) coef_ff[i] <= coef_in[i];
      end
   end

   assign lane_ctl.en_mul  = rdy_mul;
   assign lane_ctl.en_pair = rdy_pair;
   assign lane_ctl.en_sum  = rdy_sum;
   assign lane_ctl.en_out  = rdy_out;

   // one lane per result component
   for (genvar g = 0; g < DIM; g++) begin : g_lane
      hmt_lane #(
         .FRAC_BITS(FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .ctl    (lane_ctl),
         .vec    (vec_ff),
         .coef   (coef_ff[g]),
         .result (lane_res[g]),
         .sat    (lane_sat[g])
      );
   end

   assign rsp_valid          = rsp_vld_ff;
   assign rsp_data.out_a     = lane_res[0];
   assign rsp_data.out_b     = lane_res[1];
   assign rsp_data.out_c     = lane_res[2];
   assign rsp_data.out_d     = lane_res[3];
   assign rsp_data.saturated = |lane_sat;

endmodule

### rtl/hmt_lane.sv
// one output component: four products, adder tree, floor shift and saturation
module hmt_lane #(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  hmt_pkg::lane_ctl_type ctl,
   input  hmt_pkg::fixvec_type  vec,
   input  hmt_pkg::fixvec_type  coef,
   output hmt_pkg::fix_type     result,
   output logic                 sat
);
   import hmt_pkg::*;

   localparam int HI_W = SUM_W - FRAC_BITS - DATA_W + 1;

   logic signed [DATA_W-1:0] va [DIM];
   logic signed [DATA_W-1:0] ca [DIM];
   logic signed [PROD_W-1:0] prod_in [DIM];
   logic signed [PROD_W-1:0] prod_ff [DIM];
   logic signed [PAIR_W-1:0] pair_in [2];
   logic signed [PAIR_W-1:0] pair_ff [2];
   logic signed [SUM_W-1:0]  sum_in;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [HI_W-1:0]          hi_bits;
   logic                     in_range;
   logic signed [DATA_W-1:0] res_in;
   logic signed [DATA_W-1:0] res_ff;
   logic                     sat_in;
   logic                     sat_ff;

   always_comb begin
      for (int k = 0; k < DIM; k++) begin
         va[k]      = vec[k];
         ca[k]      = coef[k];
         // operands are sign copies of 32-bit values
         prod_in[k] = PROD_W'(va[k]) * PROD_W'(ca[k]);
      end
   end

   assign pair_in[0] = PAIR_W'(prod_ff[0]) + PAIR_W'(prod_ff[1]);
   assign pair_in[1] = PAIR_W'(prod_ff[2]) + PAIR_W'(prod_ff[3]);
   assign sum_in     = SUM_W'(pair_ff[0]) + SUM_W'(pair_ff[1]);

   // floor shift keeps sum bits above the fraction; the rest must be sign copies
   assign hi_bits  = sum_ff[SUM_W-1 -: HI_W];
   assign in_range = (&hi_bits) || (~|hi_bits);

   always_comb begin
      sat_in = 1'b0;
      res_in = sum_ff[FRAC_BITS +: DATA_W];
      if (!in_range) begin
         sat_in = 1'b1;
         res_in = sum_ff[SUM_W-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.en_mul) begin
         for (int k = 0; k < DIM; k++) prod_ff[k] <= prod_in[k];
      end
      if (ctl.en_pair) begin
         pair_ff[0] <= pair_in[0];
         pair_ff[1] <= pair_in[1];
      end
      if (ctl.en_sum) begin
         sum_ff <= sum_in;
      end
      if (ctl.en_out) begin
         res_ff <= res_in;
         sat_ff <= sat_in;
      end
   end

   assign result = res_ff;
   assign sat    = sat_ff;

endmodule

### tb/tb.sv
// self-checking testbench for the 4x4 homogeneous matrix transform
`timescale 1ns / 1ps
module tb;
   import hmt_pkg::*;

   localparam int FRAC         = 16;
   localparam int LATENCY      = 4;
   localparam int IDLE_PCT     = 24;
   localparam int RANDOM_WORDS = 1300;
   localparam int BURST_WORDS  = 300;
   localparam int CYCLE_LIMIT  = 200000;

   // action code the block takes and drops
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   localparam fix_type UNIT    = 32'sd1 <<< FRAC;
   localparam fix_type FIX_MAX = 32'sh7FFF_FFFF;
   localparam fix_type FIX_MIN = 32'sh8000_0000;

   // clip bounds at the width of the wide sum
   localparam logic signed [SUM_W-1:0] SUM_HI = SUM_W'(32'h7FFF_FFFF);
   localparam logic signed [SUM_W-1:0] SUM_LO = ~SUM_HI;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   // shadow copy of the coefficient matrix, row-major
   fix_type matrix_model [DIM][DIM];
   // results still owed by the block, oldest first
   rsp_type pending_results [$];
   rsp_type oldest_result;

   int  error_count = 0;
   int  cycle_count = 0;
   // when set, neither side idles
   logic calm = 1'b0;

   homogeneous_matrix_transform #(
      .FRAC_BITS(FRAC)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog: a hung handshake ends the run here
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------------

   // exact four-term dot product, floor-shifted back to fixed point and clipped
   function automatic fix_type scaled_dot(fixvec_type lhs, fixvec_type rhs,
                                          inout logic clipped);
      logic signed [SUM_W-1:0] acc;
      logic signed [SUM_W-1:0] opa;
      logic signed [SUM_W-1:0] opb;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         opa = SUM_W'(lhs[k]);
         opb = SUM_W'(rhs[k]);
         acc = acc + opa * opb;
      end
      // arithmetic shift on a signed sum is a floor
      acc = acc >>> FRAC;
      if (acc > SUM_HI) begin
         clipped = 1'b1;
         return FIX_MAX;
      end
      if (acc < SUM_LO) begin
         clipped = 1'b1;
         return FIX_MIN;
      end
      return fix_type'(acc[DATA_W-1:0]);
   endfunction

   // apply one accepted word to the shadow matrix and queue any result it owes
   task automatic predict_word(req_type w);
      fixvec_type vec;
      fixvec_type other;
      fix_type    comp [DIM];
      rsp_type    r;
      logic       clipped;
      vec[0]  = w.in_a;
      vec[1]  = w.in_b;
      vec[2]  = w.in_c;
      vec[3]  = w.in_d;
      clipped = 1'b0;
      case (w.action)
         ACT_LOAD: begin
            for (int k = 0; k < DIM; k++)
               matrix_model[w.row_index][k] = vec[k];
         end
         ACT_POINT: begin
            // w of the point is exactly one, in_d plays no part
            vec[3] = UNIT;
            for (int i = 0; i < DIM; i++) begin
               for (int k = 0; k < DIM; k++)
                  other[k] = matrix_model[i][k];
               comp[i] = scaled_dot(other, vec, clipped);
            end
         end
         ACT_ROWMUL: begin
            for (int i = 0; i < DIM; i++) begin
               for (int k = 0; k < DIM; k++)
                  other[k] = matrix_model[k][i];
               comp[i] = scaled_dot(vec, other, clipped);
            end
         end
         default: ;
      endcase
      if (w.action == ACT_POINT || w.action == ACT_ROWMUL) begin
         r.out_a     = comp[0];
         r.out_b     = comp[1];
         r.out_c     = comp[2];
         r.out_d     = comp[3];
         r.saturated = clipped;
         pending_results.push_back(r);
      end
   endtask

   // ---------------------------------------------------------------------
   // request side
   // ---------------------------------------------------------------------

   function automatic req_type make_word(logic [1:0] action, logic [1:0] row,
                                         fix_type a, fix_type b, fix_type c, fix_type d);
      req_type w;
      w.action    = action;
      w.row_index = row;
      w.in_a      = a;
      w.in_b      = b;
      w.in_c      = c;
      w.in_d      = d;
      return w;
   endfunction

   // mostly modest magnitudes so results stay in range, with a tail of
   // full-width values and the corners of the format
   function automatic fix_type pick_coeff();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 52)
         return fix_type'(int'($urandom_range(32'h000F_FFFF)) - 32'sh0008_0000);
      if (pick < 82)
         return fix_type'(int'($urandom_range(32'h01FF_FFFF)) - 32'sh0100_0000);
      if (pick < 92)
         return fix_type'($urandom);
      case ($urandom_range(5))
         0:       return FIX_MAX;
         1:       return FIX_MIN;
         2:       return UNIT;
         3:       return -UNIT;
         4:       return fix_type'(-1);
         default: return fix_type'(0);
      endcase
   endfunction

   function automatic req_type random_word();
      int unsigned pick;
      logic [1:0]  action;
      pick = $urandom_range(99);
      if (pick < 18)
         action = ACT_LOAD;
      else if (pick < 58)
         action = ACT_POINT;
      else if (pick < 95)
         action = ACT_ROWMUL;
      else
         action = ACT_UNUSED;
      return make_word(action, 2'($urandom_range(3)),
                       pick_coeff(), pick_coeff(), pick_coeff(), pick_coeff());
   endfunction

   // called and returning at a falling edge; valid stays high afterwards so
   // the next word can follow without a bubble
   task automatic send_word(req_type w);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do
         @(posedge clock);
      while (!req_ready);
      predict_word(w);
      @(negedge clock);
   endtask

   // ---------------------------------------------------------------------
   // response side
   // ---------------------------------------------------------------------

   always @(negedge clock)
      rsp_ready <= calm || ($urandom_range(99) >= IDLE_PCT);

   task automatic check_field(string label, logic [DATA_W-1:0] want,
                              logic [DATA_W-1:0] got);
      if (want !== got) begin
         error_count++;
         $display("%0t: %s expected %h actual %h", $time, label, want, got);
      end
   endtask

   // every word taken from the block is matched against the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            error_count++;
            $display("%0t: unexpected word, expected none actual %h", $time, rsp_data);
         end else begin
            oldest_result = pending_results.pop_front();
            check_field("out_a", oldest_result.out_a, rsp_data.out_a);
            check_field("out_b", oldest_result.out_b, rsp_data.out_b);
            check_field("out_c", oldest_result.out_c, rsp_data.out_c);
            check_field("out_d", oldest_result.out_d, rsp_data.out_d);
            check_field("saturated", DATA_W'(oldest_result.saturated),
                        DATA_W'(rsp_data.saturated));
         end
      end
   end

   // ---------------------------------------------------------------------
   // tests
   // ---------------------------------------------------------------------

   // matrix straight out of reset must pass points and rows through untouched
   task automatic test_identity_matrix();
      send_word(make_word(ACT_POINT, 2'd0, FIX_MAX, FIX_MIN, 0, fix_type'($urandom)));
      send_word(make_word(ACT_POINT, 2'd3, fix_type'(-1), 1, UNIT, FIX_MIN));
      send_word(make_word(ACT_ROWMUL, 2'd1, FIX_MAX, FIX_MIN, -UNIT, FIX_MAX));
      send_word(make_word(ACT_ROWMUL, 2'd2, 0, 0, 0, 0));
      send_word(make_word(ACT_UNUSED, 2'd1, FIX_MAX, FIX_MIN, FIX_MAX, FIX_MIN));
   endtask

   // corner coefficients: clipping both ways, floor on negative fractions,
   // and an unused action that must leave the matrix alone
   task automatic test_extreme_rows();
      for (int r = 0; r < DIM; r++)
         send_word(make_word(ACT_LOAD, 2'(r), FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
      send_word(make_word(ACT_POINT, 2'd0, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MIN));
      send_word(make_word(ACT_POINT, 2'd0, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MAX));
      send_word(make_word(ACT_ROWMUL, 2'd0, FIX_MIN, FIX_MAX, 0, UNIT));
      send_word(make_word(ACT_LOAD, 2'd2, FIX_MIN, FIX_MIN, FIX_MIN, FIX_MIN));
      send_word(make_word(ACT_ROWMUL, 2'd0, FIX_MAX, FIX_MAX, FIX_MAX, FIX_MAX));
      send_word(make_word(ACT_UNUSED, 2'd1, 0, 0, 0, 0));
      send_word(make_word(ACT_POINT, 2'd0, fix_type'(-1), fix_type'(-1), fix_type'(-1),
                          FIX_MAX));
      // half, tiny negative, one and a half, minus one
      send_word(make_word(ACT_LOAD, 2'd0, 32'sh0000_8000, fix_type'(-3), 32'sh0001_8000,
                          -UNIT));
      send_word(make_word(ACT_POINT, 2'd2, fix_type'(-1), 1, UNIT, 0));
      send_word(make_word(ACT_ROWMUL, 2'd3, fix_type'(-1), 0, 0, 0));
   endtask

   // random mix with gaps on both sides
   task automatic test_random_mix();
      for (int n = 0; n < RANDOM_WORDS; n++)
         send_word(random_word());
   endtask

   // full rate in both directions, with neither side idling
   task automatic test_back_to_back();
      calm = 1'b1;
      for (int n = 0; n < BURST_WORDS; n++)
         send_word(random_word());
      calm = 1'b0;
   endtask

   initial begin
      for (int i = 0; i < DIM; i++)
         for (int k = 0; k < DIM; k++)
            matrix_model[i][k] = (i == k) ? UNIT : fix_type'(0);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_identity_matrix();
      test_extreme_rows();
      test_random_mix();
      test_back_to_back();
      req_valid <= 1'b0;

      // drain, then leave room for any stray word
      while (pending_results.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);

      if (error_count == 0 && pending_results.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
